// ===== rtl/mst_pkg.sv =====
// Shared constants and types for the minimum-tracking stack.
`timescale 1ns / 1ps
package mst_pkg;

  localparam int DEPTH  = 256;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

endpackage

// ===== rtl/mst_if.sv =====
// Valid/ready channel interfaces for stack commands and stack results.
`timescale 1ns / 1ps
interface mst_cmd_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic signed [mst_pkg::DATA_W-1:0] value;

  modport source (output valid, func, value, input ready);
  modport sink (input valid, func, value, output ready);
endinterface

interface mst_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [mst_pkg::DATA_W-1:0] top_value;
  logic signed [mst_pkg::DATA_W-1:0] min_value;
  logic [mst_pkg::CNT_W-1:0]         entry_count;
  logic                              is_empty;
  logic [1:0]                        status;

  modport source (output valid, top_value, min_value, entry_count, is_empty, status,
                  input ready);
  modport sink (input valid, top_value, min_value, entry_count, is_empty, status,
                output ready);
endinterface

// ===== rtl/mst_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps
module mst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/min_tracking_stack.sv =====
// Top level of the minimum-tracking stack: control, cached tops and the two stores.
// A result is registered in S_EXEC after its command beat is accepted, once the output register is free.
// A new command beat is taken only in S_IDLE, so each command finishes before the next one; the
// registered read of the stores (the entry below each top) is what makes the S_EXEC state needed.
// A result waiting on the output register does not block the next command beat.
// Synchronous reset empties both stores by clearing their counts; contents are kept.
`timescale 1ns / 1ps
module min_tracking_stack (
  input  logic       clk,
  input  logic       rst,
  mst_cmd_if.sink    cmd,
  mst_res_if.source  res
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;

  logic                              func;
  logic signed [mst_pkg::DATA_W-1:0] value;
  logic [mst_pkg::CNT_W-1:0]         vcount;
  logic [mst_pkg::CNT_W-1:0]         mcount;
  logic signed [mst_pkg::DATA_W-1:0] top_reg;
  logic signed [mst_pkg::DATA_W-1:0] min_reg;

  logic [mst_pkg::CNT_W-1:0]         vcount_next;
  logic [mst_pkg::CNT_W-1:0]         mcount_next;
  logic signed [mst_pkg::DATA_W-1:0] top_next;
  logic signed [mst_pkg::DATA_W-1:0] min_next;
  mst_pkg::status_t                  status_next;
  logic                              vwe;
  logic                              mwe;

  logic [mst_pkg::DATA_W-1:0]        vrdata;
  logic [mst_pkg::DATA_W-1:0]        mrdata;
  logic                              accept;
  logic                              finish;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign finish    = (state == S_EXEC) && (!res.valid || res.ready);

  mst_ram #(.WIDTH(mst_pkg::DATA_W), .DEPTH(mst_pkg::DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (finish && vwe),
    .waddr (vcount[mst_pkg::ADDR_W-1:0]),
    .wdata (value),
    .re    (accept),
    .raddr (mst_pkg::ADDR_W'(vcount - mst_pkg::CNT_W'(2))),
    .rdata (vrdata)
  );

  mst_ram #(.WIDTH(mst_pkg::DATA_W), .DEPTH(mst_pkg::DEPTH)) u_min_ram (
    .clk   (clk),
    .we    (finish && mwe),
    .waddr (mcount[mst_pkg::ADDR_W-1:0]),
    .wdata (value),
    .re    (accept),
    .raddr (mst_pkg::ADDR_W'(mcount - mst_pkg::CNT_W'(2))),
    .rdata (mrdata)
  );

  always_comb begin
    vcount_next = vcount;
    mcount_next = mcount;
    top_next    = top_reg;
    min_next    = min_reg;
    status_next = mst_pkg::ST_OK;
    vwe         = 1'b0;
    mwe         = 1'b0;
    if (func == mst_pkg::FUNC_PUSH) begin
      if (vcount == mst_pkg::CNT_W'(mst_pkg::DEPTH)) begin
        status_next = mst_pkg::ST_OVERFLOW;
      end else begin
        vwe         = 1'b1;
        vcount_next = vcount + mst_pkg::CNT_W'(1);
        top_next    = value;
        if (mcount == '0 || value <= min_reg) begin
          mwe         = 1'b1;
          mcount_next = mcount + mst_pkg::CNT_W'(1);
          min_next    = value;
        end
      end
    end else begin
      if (vcount == '0) begin
        status_next = mst_pkg::ST_UNDERFLOW;
      end else begin
        vcount_next = vcount - mst_pkg::CNT_W'(1);
        top_next    = $signed(vrdata);
        if (mcount != '0 && top_reg == min_reg) begin
          mcount_next = mcount - mst_pkg::CNT_W'(1);
          min_next    = $signed(mrdata);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func  <= cmd.func;
      value <= cmd.value;
    end
    if (finish) begin
      top_reg         <= top_next;
      min_reg         <= min_next;
      res.top_value   <= (vcount_next != '0) ? top_next : '0;
      res.min_value   <= (vcount_next != '0 && mcount_next != '0) ? min_next : '0;
      res.entry_count <= vcount_next;
      res.is_empty    <= (vcount_next == '0);
      res.status      <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vcount    <= '0;
      mcount    <= '0;
      res.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (finish) begin
        vcount    <= vcount_next;
        mcount    <= mcount_next;
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

endmodule
